@@ hdl/stseq_pkg.sv @@
package stseq_pkg;

  // queue sizes
  localparam int TX_QUEUE_DEPTH = 16;
  localparam int RX_QUEUE_DEPTH = 16;
  localparam int TX_PTR_W = $clog2(TX_QUEUE_DEPTH);
  localparam int TX_CNT_W = $clog2(TX_QUEUE_DEPTH + 1);
  localparam int RX_PTR_W = $clog2(RX_QUEUE_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_QUEUE_DEPTH + 1);

  // field widths
  localparam int TONE_W   = 4;
  localparam int WORD_W   = 11;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // tone codes
  localparam logic [TONE_W-1:0] NO_TONE      = 4'hF;
  localparam logic [TONE_W-1:0] MAX_TONE     = 4'hE;
  localparam logic [TONE_W-1:0] REPEAT_RESET = 4'hE;

  // opcodes
  localparam logic [OP_W-1:0] OP_QUEUE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_DETECT = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TX_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CODE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RX_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RX_DROP  = 3'd4;

  // register byte addresses
  localparam int              APB_ADDR_W  = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_REPEAT = 3'd0;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  // tone generator divider words
  function automatic logic [WORD_W-1:0] divider_word(input logic [TONE_W-1:0] tone);
    logic [WORD_W-1:0] w;
    case (tone)
      4'd0:    w = 11'h1a4;
      4'd1:    w = 11'h3b7;
      4'd2:    w = 11'h365;
      4'd3:    w = 11'h31a;
      4'd4:    w = 11'h2d0;
      4'd5:    w = 11'h293;
      4'd6:    w = 11'h25c;
      4'd7:    w = 11'h227;
      4'd8:    w = 11'h1f8;
      4'd9:    w = 11'h1ca;
      4'd10:   w = 11'h168;
      4'd11:   w = 11'h4dc;
      4'd12:   w = 11'h40f;
      4'd13:   w = 11'h473;
      4'd14:   w = 11'h184;
      default: w = 11'h000;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/stseq_txq.sv @@
module stseq_txq
  import stseq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_ctrl_t           ctrl_i,
  input  logic [TONE_W-1:0] wdata_i,
  output logic [TONE_W-1:0] head_o,
  output q_flags_t          flags_o
);

  logic [TONE_W-1:0]   mem_q [TX_QUEUE_DEPTH];
  logic [TX_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [TX_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [TX_CNT_W-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign flags_o.full  = (count_q == TX_CNT_W'(TX_QUEUE_DEPTH));
  assign flags_o.empty = (count_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  assign do_push = ctrl_i.push && !flags_o.full;
  assign do_pop  = ctrl_i.pop && !flags_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == TX_PTR_W'(TX_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == TX_PTR_W'(TX_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/stseq_rxq.sv @@
module stseq_rxq
  import stseq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_ctrl_t           ctrl_i,
  input  logic [TONE_W-1:0] wdata_i,
  output logic [TONE_W-1:0] head_o,
  output q_flags_t          flags_o
);

  logic [TONE_W-1:0]   mem_q [RX_QUEUE_DEPTH];
  logic [RX_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RX_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RX_CNT_W-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign flags_o.full  = (count_q == RX_CNT_W'(RX_QUEUE_DEPTH));
  assign flags_o.empty = (count_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  assign do_push = ctrl_i.push && !flags_o.full;
  assign do_pop  = ctrl_i.pop && !flags_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == RX_PTR_W'(RX_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == RX_PTR_W'(RX_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/selcall_tone_sequencer.sv @@
// an accepted input item is held in the input register; its result item leaves from the result register
// throughput: one item per cycle while the master side takes every result; a waiting
// result holds the item in the input register, one more item is taken if that register
// is empty, then s_axis_tready stays low until the result is taken
// reset: rst_ni is asynchronous and active low; it empties both tone queues, ends any
// burst, forgets the last sent and last heard tones and sets repeat_code to 14
module selcall_tone_sequencer
  import stseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [3:0] tone_code, [4] tone_present
  input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] opcode

  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // [2:0] status, [13:3] tx_word,
                                               // [14] tx_word_valid, [15] tx_active,
                                               // [19:16] rx_tone, [20] rx_tone_valid

  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration register
  logic [TONE_W-1:0] repeat_code_q;

  // input register
  logic              in_valid_q;
  logic [OP_W-1:0]   op_q;
  logic [TONE_W-1:0] code_q;
  logic              present_q;

  // sequencer state
  logic              burst_q, burst_d;
  logic [TONE_W-1:0] last_sent_q, last_sent_d;
  logic [TONE_W-1:0] last_heard_q, last_heard_d;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [WORD_W-1:0]   tx_word_q, tx_word_d;
  logic                tx_word_valid_q, tx_word_valid_d;
  logic                tx_active_q;
  logic [TONE_W-1:0]   rx_tone_q, rx_tone_d;
  logic                rx_tone_valid_q, rx_tone_valid_d;

  // queue interface
  q_ctrl_t           txq_ctrl, rxq_ctrl;
  q_flags_t          txq_flags, rxq_flags;
  logic [TONE_W-1:0] txq_head, rxq_head;
  logic [TONE_W-1:0] rxq_wdata;
  logic [TONE_W-1:0] sent_tone;

  logic process;
  logic cfg_wr;

  // an item in the input register is worked on once the result slot is free
  assign process       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || process;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, repeat_code at byte address 0
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == ADDR_REPEAT[APB_ADDR_W-1:2]);
  assign prdata = (paddr[APB_ADDR_W-1:2] == ADDR_REPEAT[APB_ADDR_W-1:2])
                  ? {{(32 - TONE_W){1'b0}}, repeat_code_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_code_q <= REPEAT_RESET;
    end else if (cfg_wr) begin
      repeat_code_q <= pwdata[TONE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q      <= s_axis_tuser;
      code_q    <= s_axis_tdata[TONE_W-1:0];
      present_q <= s_axis_tdata[TONE_W];
    end
  end

  // ---------------------------------------------------------------------------
  // per-item decision logic
  // ---------------------------------------------------------------------------
  // a tone equal to the one sent just before goes out as the repeat tone
  assign sent_tone = (txq_head == last_sent_q) ? repeat_code_q : txq_head;

  always_comb begin
    burst_d         = burst_q;
    last_sent_d     = last_sent_q;
    last_heard_d    = last_heard_q;
    status_d        = ST_OK;
    tx_word_d       = '0;
    tx_word_valid_d = 1'b0;
    rx_tone_d       = '0;
    rx_tone_valid_d = 1'b0;
    txq_ctrl        = '0;
    rxq_ctrl        = '0;
    rxq_wdata       = code_q;

    if (process) begin
      case (op_q)
        OP_QUEUE: begin
          // bad code is checked before the full check
          if (code_q > MAX_TONE) begin
            status_d = ST_BAD_CODE;
          end else if (txq_flags.full) begin
            status_d = ST_TX_FULL;
          end else begin
            txq_ctrl.push = 1'b1;
            // first tone of a burst: forget what went out in the last one
            if (!burst_q) begin
              burst_d     = 1'b1;
              last_sent_d = NO_TONE;
            end
          end
        end
        OP_TICK: begin
          if (burst_q) begin
            tx_word_valid_d = 1'b1;
            if (!txq_flags.empty) begin
              txq_ctrl.pop = 1'b1;
              tx_word_d    = divider_word(sent_tone);
              last_sent_d  = sent_tone;
            end else begin
              // queue ran dry: silence the generator and end the burst
              burst_d = 1'b0;
            end
          end
        end
        OP_DETECT: begin
          if (present_q && (code_q != last_heard_q)) begin
            if (code_q == repeat_code_q) begin
              // repeat tone stands for the previous tone, if there was one
              rxq_wdata     = last_heard_q;
              rxq_ctrl.push = (last_heard_q != NO_TONE);
            end else begin
              rxq_ctrl.push = 1'b1;
            end
            if (rxq_ctrl.push && rxq_flags.full) begin
              status_d = ST_RX_DROP;
            end
            last_heard_d = code_q;
          end else begin
            // duplicate or lost tone rearms the detector
            last_heard_d = NO_TONE;
          end
        end
        OP_READ: begin
          if (rxq_flags.empty) begin
            status_d = ST_RX_EMPTY;
          end else begin
            rxq_ctrl.pop    = 1'b1;
            rx_tone_d       = rxq_head;
            rx_tone_valid_d = 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q      <= 1'b0;
      last_sent_q  <= NO_TONE;
      last_heard_q <= NO_TONE;
    end else begin
      burst_q      <= burst_d;
      last_sent_q  <= last_sent_d;
      last_heard_q <= last_heard_d;
    end
  end

  // ---------------------------------------------------------------------------
  // tone queues
  // ---------------------------------------------------------------------------
  stseq_txq u_txq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (txq_ctrl),
    .wdata_i (code_q),
    .head_o  (txq_head),
    .flags_o (txq_flags)
  );

  stseq_rxq u_rxq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rxq_ctrl),
    .wdata_i (rxq_wdata),
    .head_o  (rxq_head),
    .flags_o (rxq_flags)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      status_q        <= status_d;
      tx_word_q       <= tx_word_d;
      tx_word_valid_q <= tx_word_valid_d;
      tx_active_q     <= burst_d;
      rx_tone_q       <= rx_tone_d;
      rx_tone_valid_q <= rx_tone_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, rx_tone_valid_q, rx_tone_q, tx_active_q,
                          tx_word_valid_q, tx_word_q, status_q};

endmodule
